FILE: src/bem_pkg.sv
// Shared types and constants of the bitap exact byte matcher.
`default_nettype none
package bem_pkg;

   // Pattern and text geometry
   localparam int MaxPatternDef = 64;
   localparam int ByteW         = 8;
   localparam int NumBytes      = 256;
   localparam int CountW        = 32;

   // Counter ceiling and register reset value
   localparam logic [CountW-1:0] CountMax      = '1;
   localparam logic [CountW-1:0] LimitResetDef = '1;

   // Configuration port geometry: word index sits above the byte offset
   localparam int CsrAddrW = 3;
   localparam int CsrDataW = 32;
   localparam logic [0:0] CsrIdxLimit = 1'b0;

   // Command codes of an input word
   typedef enum logic [1:0] {
      CMD_BEGIN  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_TEXT   = 2'd2
   } cmd_type;

   // Pattern status handed from the mask store to the search stage
   typedef struct packed {
      logic has_pattern;
      logic overlong;
   } pat_info_type;

endpackage
`default_nettype wire

FILE: src/bitap_exact_byte_matcher_unit.sv
// Top level of the bitap exact byte matcher.
//
// Input words (req_) carry a command: begin a new pattern, append a pattern
// byte, or a text byte with an end-of-text mark. Every word gives exactly one
// result word (rsp_) with the match flag, start offset, running count, the
// overlong flag and the end-of-text echo.
// On acceptance the byte addresses the mask RAM; the shift-and step then runs
// on the registered mask, and the result register loads.
// Throughput is one word per cycle unless the receiver stalls; the match vector loop
// closes around the search stage and the mask RAM has one read and one write port.
// When the receiver stalls, the result holds and one more word can sit in the
// search stage; after that req_stall rises until the result is taken.
// Reset (synchronous) empties the pattern, drops the search state and sets
// position_limit to all ones. The APB port holds position_limit at address 0;
// the user must write it only while the block is idle; the block does not enforce this.
`default_nettype none
module bitap_exact_byte_matcher_unit #(
   parameter int MaxPattern = bem_pkg::MaxPatternDef
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Input channel
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [1:0]                       req_cmd,
   input  wire logic [bem_pkg::ByteW-1:0]        req_data_byte,
   input  wire logic                             req_text_end,
   // Result channel
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_match_found,
   output logic                                  rsp_position_recorded,
   output logic      [bem_pkg::CountW-1:0]       rsp_match_start,
   output logic      [bem_pkg::CountW-1:0]       rsp_match_count,
   output logic                                  rsp_pattern_too_long,
   output logic                                  rsp_text_done,
   // Configuration port
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [bem_pkg::CsrAddrW-1:0]     paddr,
   input  wire logic [bem_pkg::CsrDataW-1:0]     pwdata,
   output logic      [bem_pkg::CsrDataW-1:0]     prdata,
   output logic                                  pready
);
   import bem_pkg::*;

   localparam int IdxW = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;

   logic                  accept;
   cmd_type               cmd;
   logic [MaxPattern-1:0] mask;
   pat_info_type          info;
   logic [IdxW-1:0]       top;
   logic [CountW-1:0]     limit_ff;
   logic                  csr_write, csr_hit;

   assign accept = req_valid && !req_stall;
   assign cmd    = cmd_type'(req_cmd);

   // Register decode
   assign csr_hit   = (paddr[2] == CsrIdxLimit);
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = csr_hit ? limit_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LimitResetDef;
      end else if (csr_write && csr_hit) begin
         limit_ff <= pwdata;
      end
   end

   bem_mask_store #(
      .MaxPattern (MaxPattern)
   ) u_mask_store (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .cmd       (cmd),
      .data_byte (req_data_byte),
      .mask      (mask),
      .info      (info),
      .top       (top)
   );

   bem_search #(
      .MaxPattern (MaxPattern)
   ) u_search (
      .clock                 (clock),
      .reset                 (reset),
      .accept                (accept),
      .cmd                   (cmd),
      .text_end              (req_text_end),
      .mask                  (mask),
      .info                  (info),
      .top                   (top),
      .limit                 (limit_ff),
      .in_stall              (req_stall),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_match_found       (rsp_match_found),
      .rsp_position_recorded (rsp_position_recorded),
      .rsp_match_start       (rsp_match_start),
      .rsp_match_count       (rsp_match_count),
      .rsp_pattern_too_long  (rsp_pattern_too_long),
      .rsp_text_done         (rsp_text_done)
   );

endmodule
`default_nettype wire

FILE: src/bem_ram.sv
// Generic single-port-write RAM with bit write enables and registered read.
`default_nettype none
module bem_ram #(
   parameter int Width = 64,
   parameter int Depth = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [Width-1:0]         wr_bits,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write the enabled bits of one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int b = 0; b < Width; b++) begin
            if (wr_bits[b]) begin
               mem_ff[wr_addr][b] <= wr_data[b];
            end
         end
      end
   end

   // Register the read word; hold it when no read is asked for
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: src/bem_mask_store.sv
// Byte mask table, pattern length and overlong flag, updated as words are taken in.
`default_nettype none
module bem_mask_store #(
   parameter int MaxPattern = bem_pkg::MaxPatternDef
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       accept,
   input  wire bem_pkg::cmd_type                           cmd,
   input  wire logic [bem_pkg::ByteW-1:0]                  data_byte,
   output logic      [MaxPattern-1:0]                      mask,
   output bem_pkg::pat_info_type                           info,
   output logic      [(MaxPattern > 1 ? $clog2(MaxPattern) : 1)-1:0] top
);
   import bem_pkg::*;

   localparam int LenW = $clog2(MaxPattern + 1);
   localparam int IdxW = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;

   logic [NumBytes-1:0]   valid_ff, valid_in;
   logic [LenW-1:0]       len_ff, len_in;
   logic                  overlong_ff, overlong_in;
   logic                  mask_valid_ff;
   pat_info_type          info_ff;
   logic [IdxW-1:0]       top_ff;

   logic                  wr_en;
   logic [MaxPattern-1:0] wr_data, wr_bits, bit_sel, rd_data;
   logic [LenW-1:0]       len_m1;

   // Append, clear or leave the pattern as the accepted word asks
   always_comb begin
      valid_in    = valid_ff;
      len_in      = len_ff;
      overlong_in = overlong_ff;
      wr_en       = 1'b0;
      bit_sel     = MaxPattern'(1) << len_ff;
      wr_data     = bit_sel;
      wr_bits     = '0;
      if (accept) begin
         case (cmd)
            CMD_BEGIN: begin
               valid_in    = '0;
               len_in      = '0;
               overlong_in = 1'b0;
            end
            CMD_APPEND: begin
               if (len_ff < LenW'(MaxPattern)) begin
                  wr_en = 1'b1;
                  // a stale entry is rewritten whole, a live one gains one bit
                  wr_bits = valid_ff[data_byte] ? bit_sel : '1;
                  valid_in[data_byte] = 1'b1;
                  len_in = len_ff + LenW'(1);
               end else begin
                  overlong_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      len_m1 = len_in - LenW'(1);
   end

   // Pattern state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         len_ff      <= '0;
         overlong_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         len_ff      <= len_in;
         overlong_ff <= overlong_in;
      end
   end

   // Capture the pattern view that goes with the word just taken
   always_ff @(posedge clock) begin
      if (accept) begin
         mask_valid_ff       <= valid_ff[data_byte];
         info_ff.has_pattern <= (len_in != '0) && !overlong_in;
         info_ff.overlong    <= overlong_in;
         top_ff              <= len_m1[IdxW-1:0];
      end
   end

   bem_ram #(
      .Width (MaxPattern),
      .Depth (NumBytes)
   ) u_mask_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (data_byte),
      .wr_data (wr_data),
      .wr_bits (wr_bits),
      .rd_en   (accept),
      .rd_addr (data_byte),
      .rd_data (rd_data)
   );

   // An entry never written since the last new pattern reads as zero
   assign mask = rd_data & {MaxPattern{mask_valid_ff}};
   assign info = info_ff;
   assign top  = top_ff;

endmodule
`default_nettype wire

FILE: src/bem_search.sv
// Shift-and search stage: match vector, offset and count, plus the result register.
`default_nettype none
module bem_search #(
   parameter int MaxPattern = bem_pkg::MaxPatternDef
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       accept,
   input  wire bem_pkg::cmd_type                           cmd,
   input  wire logic                                       text_end,
   input  wire logic [MaxPattern-1:0]                      mask,
   input  wire bem_pkg::pat_info_type                      info,
   input  wire logic [(MaxPattern > 1 ? $clog2(MaxPattern) : 1)-1:0] top,
   input  wire logic [bem_pkg::CountW-1:0]                 limit,
   output logic                                            in_stall,
   output logic                                            rsp_valid,
   input  wire logic                                       rsp_stall,
   output logic                                            rsp_match_found,
   output logic                                            rsp_position_recorded,
   output logic      [bem_pkg::CountW-1:0]                 rsp_match_start,
   output logic      [bem_pkg::CountW-1:0]                 rsp_match_count,
   output logic                                            rsp_pattern_too_long,
   output logic                                            rsp_text_done
);
   import bem_pkg::*;

   // Stage one: the word whose mask is being read
   logic                  s1_valid_ff, s1_valid_in;
   cmd_type               s1_cmd_ff;
   logic                  s1_end_ff;

   // Search state
   logic [MaxPattern-1:0] vec_ff, vec_in, vec_next;
   logic [CountW-1:0]     offset_ff, offset_in;
   logic [CountW-1:0]     count_ff, count_in, count_hit;

   // Result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  found_ff, found_in;
   logic                  rec_ff, rec_in;
   logic [CountW-1:0]     start_ff, start_in;
   logic [CountW-1:0]     cnt_ff, cnt_in;
   logic                  long_ff;
   logic                  done_ff, done_in;

   logic                  out_blocked, advance, hit;
   logic [CountW-1:0]     top_ext;

   // Move stage one on whenever the result register is free or being taken
   always_comb begin
      out_blocked  = rsp_valid_ff && rsp_stall;
      advance      = s1_valid_ff && !out_blocked;
      in_stall     = s1_valid_ff && out_blocked;
      s1_valid_in  = accept || (s1_valid_ff && !advance);
      rsp_valid_in = advance || out_blocked;
   end

   // Advance the match vector and form the result
   always_comb begin
      vec_next  = ((vec_ff << 1) | MaxPattern'(1)) & mask;
      hit       = info.has_pattern && vec_next[top];
      top_ext   = CountW'(top);
      count_hit = (count_ff != CountMax) ? count_ff + CountW'(1) : count_ff;
      vec_in    = vec_ff;
      offset_in = offset_ff;
      count_in  = count_ff;
      found_in  = 1'b0;
      rec_in    = 1'b0;
      start_in  = '0;
      cnt_in    = '0;
      done_in   = 1'b0;
      case (s1_cmd_ff)
         CMD_BEGIN: begin
            vec_in    = '0;
            offset_in = '0;
            count_in  = '0;
         end
         CMD_TEXT: begin
            vec_in = vec_next;
            if (hit) begin
               found_in = 1'b1;
               rec_in   = count_ff < limit;
               start_in = (offset_ff >= top_ext) ? offset_ff - top_ext : '0;
               count_in = count_hit;
            end
            cnt_in    = count_in;
            done_in   = s1_end_ff;
            offset_in = (offset_ff != CountMax) ? offset_ff + CountW'(1) : offset_ff;
            // drop the search at the end of a text
            if (s1_end_ff) begin
               vec_in    = '0;
               offset_in = '0;
               count_in  = '0;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vec_ff       <= '0;
         offset_ff    <= '0;
         count_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            vec_ff    <= vec_in;
            offset_ff <= offset_in;
            count_ff  <= count_in;
         end
      end
   end

   // Stage one payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff <= cmd;
         s1_end_ff <= text_end;
      end
   end

   // Result payload, held while the receiver stalls
   always_ff @(posedge clock) begin
      if (advance) begin
         found_ff <= found_in;
         rec_ff   <= rec_in;
         start_ff <= start_in;
         cnt_ff   <= cnt_in;
         long_ff  <= info.overlong;
         done_ff  <= done_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_match_found       = found_ff;
   assign rsp_position_recorded = rec_ff;
   assign rsp_match_start       = start_ff;
   assign rsp_match_count       = cnt_ff;
   assign rsp_pattern_too_long  = long_ff;
   assign rsp_text_done         = done_ff;

endmodule
`default_nettype wire

FILE: src/bem_checker.sv
// Port-level checks of the matcher's result channel, bound to the top level.
`default_nettype none
module bem_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_match_found,
   input wire logic        rsp_position_recorded,
   input wire logic [31:0] rsp_match_start,
   input wire logic [31:0] rsp_match_count,
   input wire logic        rsp_pattern_too_long,
   input wire logic        rsp_text_done
);

   // Hold a stalled result word
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_match_found)
         && $stable(rsp_match_start) && $stable(rsp_match_count)
         && $stable(rsp_text_done))
      else $error("stalled result word changed");

   // A match always carries a non-zero running count
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_match_found |-> rsp_match_count != 32'd0)
      else $error("match with zero count");

   // Without a match there is no start and nothing recorded
   a_nomatch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_match_found |-> rsp_match_start == 32'd0
         && !rsp_position_recorded)
      else $error("start or record without a match");

   // An overlong pattern never matches
   a_long: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pattern_too_long |-> !rsp_match_found)
      else $error("match reported for overlong pattern");

   // Reset empties the result register
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

bind bitap_exact_byte_matcher_unit bem_checker u_bem_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_valid),
   .rsp_stall             (rsp_stall),
   .rsp_match_found       (rsp_match_found),
   .rsp_position_recorded (rsp_position_recorded),
   .rsp_match_start       (rsp_match_start),
   .rsp_match_count       (rsp_match_count),
   .rsp_pattern_too_long  (rsp_pattern_too_long),
   .rsp_text_done         (rsp_text_done)
);
`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench of the bitap exact byte matcher: prediction, stimulus, checks.
`timescale 1ns / 100ps
module tb;
   import bem_pkg::*;

   localparam int            MaxPat      = MaxPatternDef;
   localparam logic [1:0]    CmdUnused   = 2'd3;
   localparam logic [CsrAddrW-1:0] LimitAddr = CsrAddrW'(CsrIdxLimit) << 2;
   localparam int unsigned   HoldCycles  = 300;
   localparam int unsigned   SettleLimit = 5000;
   localparam int unsigned   DrainCycles = 6;
   localparam int unsigned   MaxReports  = 40;
   localparam time           TimeoutNs   = 3_000_000;

   // One result word as the block should give it
   typedef struct packed {
      logic        found;
      logic        recorded;
      logic [31:0] start;
      logic [31:0] count;
      logic        too_long;
      logic        done;
   } match_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_cmd = CMD_BEGIN;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_text_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_match_found;
   logic        rsp_position_recorded;
   logic [31:0] rsp_match_start;
   logic [31:0] rsp_match_count;
   logic        rsp_pattern_too_long;
   logic        rsp_text_done;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [CsrAddrW-1:0] paddr = '0;
   logic [CsrDataW-1:0] pwdata = '0;
   logic [CsrDataW-1:0] prdata;
   logic        pready;

   bitap_exact_byte_matcher_unit u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_cmd               (req_cmd),
      .req_data_byte         (req_data_byte),
      .req_text_end          (req_text_end),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_match_found       (rsp_match_found),
      .rsp_position_recorded (rsp_position_recorded),
      .rsp_match_start       (rsp_match_start),
      .rsp_match_count       (rsp_match_count),
      .rsp_pattern_too_long  (rsp_pattern_too_long),
      .rsp_text_done         (rsp_text_done),
      .psel                  (psel),
      .penable               (penable),
      .pwrite                (pwrite),
      .paddr                 (paddr),
      .pwdata                (pwdata),
      .prdata                (prdata),
      .pready                (pready)
   );

   // Predicted matcher state
   logic [63:0] pat_masks [NumBytes];
   logic [63:0] shift_vec;
   int unsigned pat_len;
   logic        pat_overlong;
   logic [31:0] text_pos;
   logic [31:0] hit_count;
   logic [31:0] limit_reg;

   match_result_type pending_results [$];

   int unsigned fail_count   = 0;
   int unsigned words_sent   = 0;
   int unsigned text_words   = 0;
   int unsigned hits_seen    = 0;
   int unsigned recorded_seen = 0;
   int unsigned input_stalls = 0;
   int unsigned limit_writes = 0;
   int unsigned gap_pct      = 0;
   int unsigned stall_pct    = 0;
   int unsigned hold_ticket  = 0;
   int unsigned hold_served  = 0;
   int unsigned hold_left    = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Clear the whole search state, as on reset
   initial begin
      for (int i = 0; i < NumBytes; i++) pat_masks[i] = '0;
      shift_vec    = '0;
      pat_len      = 0;
      pat_overlong = 1'b0;
      text_pos     = '0;
      hit_count    = '0;
      limit_reg    = LimitResetDef;
   end

   initial begin
      #(TimeoutNs);
      $display("tb: failure");
      $finish;
   end

   // Advance the predicted state by one word and return its result
   function automatic match_result_type bitap_step(logic [1:0] cmd, logic [7:0] b, logic last);
      match_result_type r;
      logic [31:0]   here;
      int unsigned   top;
      r = '0;
      case (cmd)
         CMD_BEGIN: begin
            for (int i = 0; i < NumBytes; i++) pat_masks[i] = '0;
            pat_len      = 0;
            pat_overlong = 1'b0;
            shift_vec    = '0;
            text_pos     = '0;
            hit_count    = '0;
         end
         CMD_APPEND: begin
            if (pat_len < MaxPat) begin
               pat_masks[b][pat_len] = 1'b1;
               pat_len++;
            end else begin
               pat_overlong = 1'b1;
            end
         end
         CMD_TEXT: begin
            here      = text_pos;
            shift_vec = ((shift_vec << 1) | 64'd1) & pat_masks[b];
            if (pat_len != 0 && !pat_overlong) begin
               top = pat_len - 1;
               if (shift_vec[top]) begin
                  r.found    = 1'b1;
                  r.recorded = hit_count < limit_reg;
                  r.start    = (here >= top) ? here - top : '0;
                  if (hit_count != CountMax) hit_count++;
               end
            end
            if (text_pos != CountMax) text_pos++;
            r.done  = last;
            r.count = hit_count;
         end
         default: ;
      endcase
      r.too_long = pat_overlong;
      if (cmd == CMD_TEXT && last) begin
         shift_vec = '0;
         text_pos  = '0;
         hit_count = '0;
      end
      return r;
   endfunction

   // Offer one word, idling first at random, and predict it once taken
   task automatic send_word(logic [1:0] cmd, logic [7:0] b, logic last);
      while ($urandom_range(99) < gap_pct) begin
         req_valid     <= 1'b0;
         req_cmd       <= 2'($urandom_range(3));
         req_data_byte <= 8'($urandom_range(255));
         req_text_end  <= 1'($urandom_range(1));
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_data_byte <= b;
      req_text_end  <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(bitap_step(cmd, b, last));
      if (cmd != CmdUnused) words_sent++;
      if (cmd == CMD_TEXT) text_words++;
   endtask

   // Drop valid and wait for every expected word to come back
   task automatic settle_results();
      int unsigned waited;
      waited = 0;
      req_valid <= 1'b0;
      while (pending_results.size() != 0 && waited < SettleLimit) begin
         @(posedge clock);
         waited++;
      end
      if (pending_results.size() != 0) begin
         fail_count++;
         $display("%0t ns: %0d results never arrived", $time, pending_results.size());
         pending_results.delete();
      end
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Write position_limit, then read it back
   task automatic csr_write_limit(logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= LimitAddr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (pready !== 1'b1) @(posedge clock);
      limit_reg = value;
      limit_writes++;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (pready !== 1'b1) @(posedge clock);
      check_field("position_limit readback", limit_reg, prdata);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         fail_count++;
         if (fail_count <= MaxReports)
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   // Drive the receiver's stall: a long hold when asked, else random
   always @(posedge clock) begin
      if (hold_served != hold_ticket) begin
         hold_served = hold_ticket;
         hold_left   = HoldCycles;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Compare each taken result word with the oldest expectation
   always @(posedge clock) begin
      match_result_type want;
      if (!reset && req_valid && req_stall) input_stalls++;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            fail_count++;
            if (fail_count <= MaxReports)
               $display("%0t ns: result word with none expected, expected none, actual count %h",
                        $time, rsp_match_count);
         end else begin
            want = pending_results.pop_front();
            if (want.found) hits_seen++;
            if (want.recorded) recorded_seen++;
            check_field("match_found", want.found, rsp_match_found);
            check_field("position_recorded", want.recorded, rsp_position_recorded);
            check_field("match_start", want.start, rsp_match_start);
            check_field("match_count", want.count, rsp_match_count);
            check_field("pattern_too_long", want.too_long, rsp_pattern_too_long);
            check_field("text_done", want.done, rsp_text_done);
         end
      end
   end

   function automatic logic [7:0] pick_symbol(logic [7:0] base, int unsigned span, bit wide);
      if (wide) return 8'($urandom_range(255));
      return base + 8'($urandom_range(span));
   endfunction

   // Load one random pattern and search a few texts, some with the pattern planted
   task automatic search_round();
      logic [7:0]  pat [$];
      logic [7:0]  txt [$];
      logic [7:0]  base;
      int unsigned plen, span, ntext, tlen, pos, sel;
      bit          wide;
      sel  = $urandom_range(99);
      base = 8'($urandom_range(255));
      span = $urandom_range(1, 3);
      wide = ($urandom_range(9) == 0);
      if (sel < 70)      plen = $urandom_range(1, 6);
      else if (sel < 85) plen = $urandom_range(7, MaxPat - 1);
      else if (sel < 90) plen = MaxPat;
      else if (sel < 95) plen = $urandom_range(MaxPat + 1, MaxPat + 4);
      else               plen = 0;
      send_word(CMD_BEGIN, 8'($urandom_range(255)), 1'($urandom_range(1)));
      for (int i = 0; i < plen; i++) begin
         pat.push_back(pick_symbol(base, span, wide));
         send_word(CMD_APPEND, pat[i], 1'($urandom_range(1)));
         if ($urandom_range(99) < 3) send_word(CmdUnused, 8'($urandom_range(255)), 1'b1);
      end
      ntext = $urandom_range(1, 3);
      for (int t = 0; t < ntext; t++) begin
         txt.delete();
         tlen = $urandom_range(1, 20);
         for (int i = 0; i < tlen; i++) txt.push_back(pick_symbol(base, span, wide));
         if (plen != 0 && $urandom_range(99) < 60) begin
            pos = $urandom_range(0, tlen);
            for (int k = 0; k < plen; k++) txt.insert(pos + k, pat[k]);
         end
         for (int i = 0; i < txt.size(); i++) begin
            // break the sequence now and then: stray append, restart or unused word
            sel = $urandom_range(199);
            if (sel < 3)      send_word(CMD_APPEND, pick_symbol(base, span, wide), 1'b0);
            else if (sel < 4) send_word(CMD_BEGIN, 8'($urandom_range(255)), 1'b0);
            else if (sel < 7) send_word(CmdUnused, 8'($urandom_range(255)),
                                        1'($urandom_range(1)));
            send_word(CMD_TEXT, txt[i],
                      (i == txt.size() - 1) ? ($urandom_range(9) != 0) : 1'b0);
         end
      end
   endtask

   task automatic run_searches(int unsigned target);
      int unsigned first;
      first = words_sent;
      while (words_sent - first < target) search_round();
   endtask

   // Extremes of the byte, overlapping matches, empty pattern, unused command
   task automatic test_directed();
      gap_pct   = 0;
      stall_pct = 0;
      send_word(CMD_BEGIN, 8'hFF, 1'b1);
      send_word(CMD_TEXT, 8'h41, 1'b0);
      send_word(CMD_TEXT, 8'h00, 1'b1);
      send_word(CMD_APPEND, 8'h00, 1'b1);
      send_word(CMD_APPEND, 8'hFF, 1'b0);
      send_word(CMD_APPEND, 8'h00, 1'b0);
      send_word(CMD_TEXT, 8'h00, 1'b0);
      send_word(CMD_TEXT, 8'hFF, 1'b0);
      send_word(CMD_TEXT, 8'h00, 1'b0);
      send_word(CMD_TEXT, 8'hFF, 1'b0);
      send_word(CMD_TEXT, 8'h00, 1'b1);
      send_word(CmdUnused, 8'hA5, 1'b1);
      send_word(CMD_TEXT, 8'h00, 1'b1);
      send_word(CMD_BEGIN, 8'h00, 1'b0);
      send_word(CMD_APPEND, 8'h80, 1'b0);
      send_word(CMD_TEXT, 8'h80, 1'b0);
      send_word(CMD_TEXT, 8'h80, 1'b0);
      send_word(CMD_TEXT, 8'h7F, 1'b0);
      send_word(CMD_TEXT, 8'h80, 1'b1);
      settle_results();
   endtask

   // Sweep position_limit over zero, small values and a random one
   task automatic test_position_limit();
      logic [31:0] limits [5];
      limits = '{32'd0, 32'd1, 32'd3, 32'($urandom_range(2, 6)), $urandom()};
      gap_pct   = 28;
      stall_pct = 28;
      foreach (limits[i]) begin
         csr_write_limit(limits[i]);
         run_searches(20);
         settle_results();
      end
   endtask

   // Run random searches under each mix of sender gaps and receiver stalls
   task automatic test_idle_mixes();
      int unsigned gaps [4]   = '{0, 66, 0, 28};
      int unsigned stalls [4] = '{0, 0, 66, 28};
      csr_write_limit($urandom_range(1, 4));
      foreach (gaps[i]) begin
         gap_pct   = gaps[i];
         stall_pct = stalls[i];
         run_searches(70);
      end
      settle_results();
   endtask

   // Hold the receiver off while words flow, drain fully, then run again under random stalls
   task automatic test_backpressure();
      gap_pct   = 0;
      stall_pct = 0;
      hold_ticket++;
      run_searches(40);
      settle_results();
      stall_pct = 20;
      run_searches(20);
      settle_results();
   endtask

   // Back to the widest limit
   task automatic test_full_limit();
      gap_pct   = 10;
      stall_pct = 10;
      csr_write_limit(CountMax);
      run_searches(30);
      settle_results();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_position_limit();
      test_idle_mixes();
      test_backpressure();
      test_full_limit();
      $display("summary: %0d words (%0d text bytes), %0d matches, %0d with recorded position",
               words_sent, text_words, hits_seen, recorded_seen);
      $display("summary: %0d limit writes, %0d cycles with the input stalled, %0d failures",
               limit_writes, input_stalls, fail_count);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
